// ----- rtl/dqhr_pkg.sv -----
// Package for the deque with half rotate: opcodes, status codes, sizes.
// No dependencies.
package dqhr_pkg;

    localparam int CAPACITY_DEF = 256;

    localparam logic [2:0] OP_INS_HEAD = 3'd0;
    localparam logic [2:0] OP_INS_TAIL = 3'd1;
    localparam logic [2:0] OP_REM_HEAD = 3'd2;
    localparam logic [2:0] OP_REM_TAIL = 3'd3;
    localparam logic [2:0] OP_SWAP     = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_REMOVED = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [31:0] removed_value;
        logic [1:0]  status;
        logic [8:0]  size;
        logic [7:0]  middle_position;
    } result_t;

endpackage

// ----- rtl/deque_with_half_rotate.sv -----
// Top level of the deque with half rotate: stream ports around the sequencer.
// Depends on dqhr_pkg and dqhr_ctrl.
//
//  channel | dir | payload
//  s_axis  | in  | tdata: opcode[2:0], value[34:3], zero fill to 40 bits
//  m_axis  | out | tdata: removed_value[31:0], status[33:32], size[42:34],
//          |     |        middle_position[50:43], zero fill to 56 bits
//
// Insert or remove steps: accept, slot read, link update, middle read, result;
// a swap of two or more skips the middle read; other ops: accept, slot read, result.
// After reset the free-slot RAM is filled with tready low.
// A result waits in its register until taken; tready is high in the next cycle.
module deque_with_half_rotate #(
    parameter int CAPACITY = dqhr_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // opcode, value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // removed_value, status, size, middle_position
);

    dqhr_pkg::result_t res;

    dqhr_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .clk,
        .rst_n,
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tdata[2:0]),
        .in_value  (s_axis_tdata[34:3]),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {5'd0, res.middle_position, res.size, res.status,
                           res.removed_value};

endmodule

// ----- rtl/dqhr_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
module dqhr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/dqhr_ctrl.sv -----
// Sequencer for the deque: pointers, count, free stack and link updates.
// Depends on dqhr_pkg and dqhr_ram.
module dqhr_ctrl #(
    parameter int CAPACITY = dqhr_pkg::CAPACITY_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           in_op,
    input  logic [31:0]          in_value,
    output logic                 res_valid,
    input  logic                 res_ready,
    output dqhr_pkg::result_t    res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_RD1, S_RD2, S_FIN, S_OUT
    } state_t;

    state_t state_reg;
    logic [AW-1:0] init_reg;
    logic [2:0]    op_reg;
    logic [31:0]   val_reg;
    logic [AW-1:0] head_reg, tail_reg, mid_reg, slot_reg;
    logic [CW-1:0] count_reg, ftop_reg;
    logic [7:0]    midx_reg;
    logic [31:0]   rval_reg;
    logic [1:0]    stat_reg;

    // memories
    logic          v_we, n_we, p_we, f_we;
    logic [AW-1:0] v_wa, n_wa, p_wa, f_wa, v_ra, n_ra, p_ra, f_ra;
    logic [31:0]   v_wd, v_rd;
    logic [AW-1:0] n_wd, p_wd, f_wd, n_rd, p_rd, f_rd;

    dqhr_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val (.clk, .we(v_we), .waddr(v_wa),
        .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
    dqhr_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_next (.clk, .we(n_we), .waddr(n_wa),
        .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));
    dqhr_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_prev (.clk, .we(p_we), .waddr(p_wa),
        .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
    dqhr_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free (.clk, .we(f_we), .waddr(f_wa),
        .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));

    logic [CW-1:0] cnt_inc, cnt_dec;
    logic [7:0]    midx_inc, midx_dec;
    assign cnt_inc  = count_reg + 1'b1;
    assign cnt_dec  = count_reg - 1'b1;
    assign midx_inc = 8'(cnt_inc >> 1) + 8'd1;
    assign midx_dec = 8'(cnt_dec >> 1) + 8'd1;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res       = {rval_reg, stat_reg, 9'(count_reg), midx_reg};

    logic is_ins, is_rem;
    assign is_ins = (op_reg == dqhr_pkg::OP_INS_HEAD) || (op_reg == dqhr_pkg::OP_INS_TAIL);
    assign is_rem = (op_reg == dqhr_pkg::OP_REM_HEAD) || (op_reg == dqhr_pkg::OP_REM_TAIL);

    // Memory port control, by state
    always_comb
    begin
        v_we = 1'b0; n_we = 1'b0; p_we = 1'b0; f_we = 1'b0;
        v_wa = slot_reg; v_wd = val_reg;
        n_wa = tail_reg; n_wd = head_reg;
        p_wa = head_reg; p_wd = tail_reg;
        f_wa = init_reg; f_wd = init_reg;
        v_ra = head_reg; n_ra = mid_reg; p_ra = mid_reg;
        f_ra = AW'(ftop_reg - 1'b1);
        case (state_reg)
            S_INIT:
            begin
                f_we = 1'b1;
            end
            S_IDLE:
            begin
                f_ra = AW'(ftop_reg - 1'b1);
            end
            S_RD1:
            begin
                // read the slot or head/tail neighbor
                if (op_reg == dqhr_pkg::OP_REM_HEAD)
                begin
                    v_ra = head_reg; n_ra = head_reg;
                end
                else if (op_reg == dqhr_pkg::OP_REM_TAIL)
                begin
                    v_ra = tail_reg; p_ra = tail_reg;
                end
                else if (op_reg == dqhr_pkg::OP_SWAP)
                begin
                    p_ra = mid_reg;
                    n_we = 1'b1; n_wa = tail_reg; n_wd = head_reg;
                    p_we = 1'b1; p_wa = head_reg; p_wd = tail_reg;
                end
            end
            S_RD2:
            begin
                if (is_ins && count_reg != '0)
                begin
                    v_we = 1'b1;
                    if (op_reg == dqhr_pkg::OP_INS_HEAD)
                    begin
                        n_we = 1'b1; n_wa = slot_reg; n_wd = head_reg;
                        p_we = 1'b1; p_wa = head_reg; p_wd = slot_reg;
                    end
                    else
                    begin
                        n_we = 1'b1; n_wa = tail_reg; n_wd = slot_reg;
                        p_we = 1'b1; p_wa = slot_reg; p_wd = tail_reg;
                    end
                end
                else if (is_ins)
                begin
                    v_we = 1'b1;
                end
                else if (is_rem)
                begin
                    // push freed slot
                    f_we = (ftop_reg < CAP_C);
                    f_wa = AW'(ftop_reg);
                    f_wd = slot_reg;
                end
                n_ra = mid_reg; p_ra = mid_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            init_reg  <= '0;
            ftop_reg  <= CAP_C;
            head_reg  <= '0;
            tail_reg  <= '0;
            mid_reg   <= '0;
            count_reg <= '0;
            midx_reg  <= '0;
            op_reg    <= '0;
            val_reg   <= '0;
            slot_reg  <= '0;
            rval_reg  <= '0;
            stat_reg  <= dqhr_pkg::ST_DONE;
        end
        else
        begin
            case (state_reg)
                S_INIT:
                begin
                    init_reg <= init_reg + 1'b1;
                    if (init_reg == AW'(CAPACITY - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= in_op;
                        val_reg   <= in_value;
                        state_reg <= S_RD1;
                    end
                end
                S_RD1:
                begin
                    rval_reg  <= '0;
                    stat_reg  <= dqhr_pkg::ST_DONE;
                    state_reg <= S_OUT;
                    if (is_ins)
                    begin
                        if (count_reg >= CAP_C || ftop_reg == '0)
                        begin
                            stat_reg <= dqhr_pkg::ST_FULL;
                        end
                        else
                        begin
                            slot_reg  <= f_rd;
                            ftop_reg  <= ftop_reg - 1'b1;
                            state_reg <= S_RD2;
                        end
                    end
                    else if (is_rem)
                    begin
                        if (count_reg == '0)
                        begin
                            stat_reg <= dqhr_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            slot_reg  <= (op_reg == dqhr_pkg::OP_REM_HEAD) ? head_reg
                                                                            : tail_reg;
                            state_reg <= S_RD2;
                        end
                    end
                    else if (op_reg == dqhr_pkg::OP_SWAP && count_reg >= CW'(2))
                    begin
                        state_reg <= S_RD2;
                    end
                end
                S_RD2:
                begin
                    // mid neighbors valid next cycle; the head/tail reads are here
                    state_reg <= S_FIN;
                    if (is_ins)
                    begin
                        count_reg <= cnt_inc;
                        midx_reg  <= midx_inc;
                        if (count_reg == '0)
                        begin
                            head_reg <= slot_reg; tail_reg <= slot_reg;
                            mid_reg  <= slot_reg;
                        end
                        else if (op_reg == dqhr_pkg::OP_INS_HEAD)
                        begin
                            head_reg <= slot_reg;
                        end
                        else
                        begin
                            tail_reg <= slot_reg;
                        end
                    end
                    else if (is_rem)
                    begin
                        count_reg <= cnt_dec;
                        midx_reg  <= midx_dec;
                        rval_reg  <= v_rd;
                        stat_reg  <= dqhr_pkg::ST_REMOVED;
                        if (ftop_reg < CAP_C)
                        begin
                            ftop_reg <= ftop_reg + 1'b1;
                        end
                        if (cnt_dec == '0)
                        begin
                            head_reg <= '0; tail_reg <= '0; mid_reg <= '0;
                        end
                        else if (op_reg == dqhr_pkg::OP_REM_HEAD)
                        begin
                            head_reg <= n_rd;
                        end
                        else
                        begin
                            tail_reg <= p_rd;
                        end
                    end
                    else
                    begin
                        head_reg <= mid_reg;
                        tail_reg <= p_rd;
                        mid_reg  <= count_reg[0] ? tail_reg : head_reg;
                        state_reg <= S_OUT;
                    end
                end
                S_FIN:
                begin
                    // middle moves using links read in the previous step
                    state_reg <= S_OUT;
                    if (is_ins && count_reg != CW'(1))
                    begin
                        if (op_reg == dqhr_pkg::OP_INS_HEAD && count_reg[0])
                        begin
                            mid_reg <= p_rd;
                        end
                        else if (op_reg == dqhr_pkg::OP_INS_TAIL && !count_reg[0])
                        begin
                            // one-entry list: its next link was written as it was read
                            mid_reg <= (count_reg == CW'(2)) ? slot_reg : n_rd;
                        end
                    end
                    else if (is_rem && count_reg != '0)
                    begin
                        if (op_reg == dqhr_pkg::OP_REM_HEAD && !count_reg[0])
                        begin
                            mid_reg <= n_rd;
                        end
                        else if (op_reg == dqhr_pkg::OP_REM_TAIL && count_reg[0])
                        begin
                            mid_reg <= p_rd;
                        end
                    end
                end
                S_OUT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- sim/dqhr_checker.sv -----
// Checker for the deque with half rotate: watches both stream channels,
// predicts each result beat and compares it field by field. Depends on dqhr_pkg.
`timescale 1ns / 1ps

module dqhr_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,
    output int          errors,
    output int          pending
);

    localparam int CAP = dqhr_pkg::CAPACITY_DEF;

    logic [31:0]       vals   [CAP];
    logic [7:0]        nxt    [CAP];
    logic [7:0]        prv    [CAP];
    logic [7:0]        freel  [CAP];
    int                free_top;
    logic [7:0]        head, tail, mid;
    int                cnt;
    logic [7:0]        mid_pos;
    dqhr_pkg::result_t awaited[$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic dqhr_pkg::result_t apply_op(input logic [2:0] op,
                                                   input logic [31:0] val);
        dqhr_pkg::result_t r;
        logic [7:0]        s, oh, ot;
        r = '0;
        r.status = dqhr_pkg::ST_DONE;
        if (op == dqhr_pkg::OP_INS_HEAD || op == dqhr_pkg::OP_INS_TAIL)
        begin
            if (cnt >= CAP || free_top == 0)
            begin
                r.status = dqhr_pkg::ST_FULL;
            end
            else
            begin
                free_top--;
                s = freel[free_top];
                vals[s] = val;
                cnt++;
                mid_pos = 8'(cnt / 2 + 1);
                if (cnt == 1)
                begin
                    head = s; tail = s; mid = s;
                end
                else if (op == dqhr_pkg::OP_INS_HEAD)
                begin
                    nxt[s] = head; prv[head] = s; head = s;
                    if (cnt[0]) mid = prv[mid];
                end
                else
                begin
                    nxt[tail] = s; prv[s] = tail; tail = s;
                    if (!cnt[0]) mid = nxt[mid];
                end
            end
        end
        else if (op == dqhr_pkg::OP_REM_HEAD || op == dqhr_pkg::OP_REM_TAIL)
        begin
            if (cnt == 0)
            begin
                r.status = dqhr_pkg::ST_EMPTY;
            end
            else
            begin
                cnt--;
                mid_pos = 8'(cnt / 2 + 1);
                s = (op == dqhr_pkg::OP_REM_HEAD) ? head : tail;
                r.removed_value = vals[s];
                if (cnt == 0)
                begin
                    head = '0; tail = '0; mid = '0;
                end
                else if (op == dqhr_pkg::OP_REM_HEAD)
                begin
                    head = nxt[s];
                    if (!cnt[0]) mid = nxt[mid];
                end
                else
                begin
                    tail = prv[s];
                    if (cnt[0]) mid = prv[mid];
                end
                if (free_top < CAP)
                begin
                    freel[free_top] = s;
                    free_top++;
                end
                r.status = dqhr_pkg::ST_REMOVED;
            end
        end
        else if (op == dqhr_pkg::OP_SWAP && cnt >= 2)
        begin
            oh = head; ot = tail;
            head = mid;
            tail = prv[mid];
            nxt[ot] = oh; prv[oh] = ot;
            mid = cnt[0] ? ot : oh;
        end
        r.size = 9'(cnt);
        r.middle_position = mid_pos;
        return r;
    endfunction

    always @(posedge clk)
    begin
        dqhr_pkg::result_t got, want;
        if (!rst_n)
        begin
            for (int i = 0; i < CAP; i++) freel[i] = 8'(i);
            free_top = CAP;
            head = '0; tail = '0; mid = '0; cnt = 0; mid_pos = '0;
            awaited.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.removed_value   = m_axis_tdata[31:0];
                got.status          = m_axis_tdata[33:32];
                got.size            = m_axis_tdata[42:34];
                got.middle_position = m_axis_tdata[50:43];
                if (awaited.size() == 0)
                begin
                    report("unexpected result beat", m_axis_tdata[31:0], '0);
                end
                else
                begin
                    want = awaited.pop_front();
                    if (got.removed_value !== want.removed_value)
                        report("removed_value", got.removed_value, want.removed_value);
                    if (got.status !== want.status)
                        report("status", 32'(got.status), 32'(want.status));
                    if (got.size !== want.size)
                        report("size", 32'(got.size), 32'(want.size));
                    if (got.middle_position !== want.middle_position)
                        report("middle_position", 32'(got.middle_position),
                               32'(want.middle_position));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                awaited.push_back(apply_op(s_axis_tdata[2:0], s_axis_tdata[34:3]));
        end
        pending = awaited.size();
    end

endmodule

// ----- sim/tb.sv -----
// Top of the deque with half rotate bench: clock, reset, operation stimulus
// and verdict. Depends on dqhr_pkg, deque_with_half_rotate and dqhr_checker.
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [55:0] m_axis_tdata;
    int          errors;
    int          pending;
    int          idle_cycles = 0;
    int          depth_model = 0;   // rough occupancy, steers random op mix
    bit          steady_rx = 0;

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    deque_with_half_rotate dut (.*);

    dqhr_checker chk (.*);

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random stalls per beat, with stall-free stretches
    always
    begin
        int w;
        @(posedge clk);
        w = steady_rx ? 0 : $urandom_range(0, 13);
        repeat (w) @(posedge clk);
        m_axis_tready <= 1;
        do @(posedge clk); while (!m_axis_tvalid);
        m_axis_tready <= 0;
    end

    task automatic send_op(input logic [2:0] op, input logic [31:0] val, input bit no_gap);
        int w;
        w = no_gap ? 0 : $urandom_range(0, 13);
        if (w > 0)
        begin
            s_axis_tvalid <= 0;
            repeat (w) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {5'b0, val, op};
        do @(posedge clk); while (!s_axis_tready);
        if (op == dqhr_pkg::OP_INS_HEAD || op == dqhr_pkg::OP_INS_TAIL)
        begin
            if (depth_model < dqhr_pkg::CAPACITY_DEF) depth_model++;
        end
        else if ((op == dqhr_pkg::OP_REM_HEAD || op == dqhr_pkg::OP_REM_TAIL)
                 && depth_model > 0)
            depth_model--;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin
        logic [2:0]  op;
        logic [31:0] v;
        int          target;
        bit          burst;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty removes, single-element swap, extremes, unused codes
        send_op(dqhr_pkg::OP_REM_HEAD, 32'hFFFF_FFFF, 0);
        send_op(dqhr_pkg::OP_REM_TAIL, 32'h0, 0);
        send_op(dqhr_pkg::OP_SWAP, 32'h0, 0);
        send_op(dqhr_pkg::OP_INS_HEAD, 32'h8000_0000, 0);
        send_op(dqhr_pkg::OP_SWAP, 32'h0, 0);
        send_op(dqhr_pkg::OP_INS_TAIL, 32'h7FFF_FFFF, 1);
        send_op(dqhr_pkg::OP_SWAP, 32'h0, 1);
        send_op(dqhr_pkg::OP_INS_HEAD, 32'hFFFF_FFFF, 0);
        send_op(dqhr_pkg::OP_INS_TAIL, 32'h0, 0);
        send_op(dqhr_pkg::OP_SWAP, 32'h0, 0);
        send_op(3'd5, 32'hAAAA_5555, 0);
        send_op(3'd6, 32'h5555_AAAA, 0);
        send_op(3'd7, 32'h1234_5678, 0);
        send_op(dqhr_pkg::OP_REM_HEAD, 32'h0, 0);
        send_op(dqhr_pkg::OP_REM_TAIL, 32'h0, 0);
        send_op(dqhr_pkg::OP_REM_HEAD, 32'h0, 0);
        send_op(dqhr_pkg::OP_REM_TAIL, 32'h0, 0);
        send_op(dqhr_pkg::OP_REM_HEAD, 32'h0, 0);   // emptied: middle reads 1
        drain_results();

        // fill past capacity, swap a full list, then drain it; no stalls here
        steady_rx = 1;
        for (int i = 0; i < dqhr_pkg::CAPACITY_DEF + 3; i++)
            send_op(3'($urandom_range(0, 1)), $urandom, 1);
        send_op(dqhr_pkg::OP_SWAP, 32'h0, 1);
        for (int i = 0; i < dqhr_pkg::CAPACITY_DEF + 2; i++)
            send_op(3'($urandom_range(2, 3)), $urandom, 1);
        steady_rx = 0;
        drain_results();

        // random: walk occupancy between low and high targets with swaps mixed in
        target = 8;
        for (int n = 0; n < 1160; n++)
        begin
            if (n % 150 == 0)
            begin
                target = $urandom_range(0, 3) == 0 ? $urandom_range(200, 260)
                                                   : $urandom_range(1, 20);
                steady_rx = ($urandom_range(0, 3) == 0);
            end
            burst = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1:    op = dqhr_pkg::OP_SWAP;
                2:       op = 3'($urandom_range(0, 7));
                default: op = (depth_model < target) ? 3'($urandom_range(0, 1))
                                                     : 3'($urandom_range(2, 3));
            endcase
            v = $urandom;
            send_op(op, v, burst);
            if (n == 580) drain_results();
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
